// ===== hdl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int unsigned COEF_W    = 16;
  localparam int unsigned ROOT_W    = 34;
  localparam int unsigned CNT_W     = 2;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned D_PAIRS   = 17;

endpackage

// ===== hdl/qrs_divider.sv =====
// ----------------------------------------------------------------------------
// qrs_divider
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
module qrs_divider #(
  parameter int unsigned NUM_W = 56,
  parameter int unsigned DEN_W = 18,
  parameter int unsigned TAG_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0]        tag_i,
  output logic                    valid_o,
  output logic signed [NUM_W-1:0] quo_o,
  output logic [TAG_W-1:0]        tag_o
);

  logic              vld_q [NUM_W+1];
  logic [NUM_W-1:0]  num_q [NUM_W+1];
  logic [NUM_W-1:0]  quo_q [NUM_W+1];
  logic [NUM_W:0]    rem_q [NUM_W+1];
  logic [DEN_W-1:0]  den_q [NUM_W+1];
  logic              neg_q [NUM_W+1];
  logic [TAG_W-1:0]  tag_q [NUM_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NUM_W; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i <= NUM_W; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      den_q[0] <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      neg_q[0] <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      tag_q[0] <= tag_i;
      for (int i = 1; i <= NUM_W; i++) begin
        logic [NUM_W:0] r;
        r = {rem_q[i-1][NUM_W-1:0], num_q[i-1][NUM_W-i]};
        if (r >= (NUM_W+1)'(den_q[i-1])) begin
          rem_q[i] <= r - (NUM_W+1)'(den_q[i-1]);
          quo_q[i] <= quo_q[i-1] | (NUM_W'(1) << (NUM_W-i));
        end else begin
          rem_q[i] <= r;
          quo_q[i] <= quo_q[i-1];
        end
        num_q[i] <= num_q[i-1];
        den_q[i] <= den_q[i-1];
        neg_q[i] <= neg_q[i-1];
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[NUM_W];
  assign quo_o   = neg_q[NUM_W] ? -$signed(quo_q[NUM_W]) : $signed(quo_q[NUM_W]);
  assign tag_o   = tag_q[NUM_W];

endmodule

// ===== hdl/quadratic_root_solver_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Real roots of a*x^2+b*x+c=0 in signed fixed point.
// ----------------------------------------------------------------------------
// Usage: send a, b, c on the s_axis channel; one result per transfer leaves
// on m_axis with the root count and up to two roots (FRAC_BITS fraction bits).
// Pipeline: 2 stages form the discriminant, the square root takes an input
// register and one stage per root bit (D_PAIRS+FRAC_BITS+1 stages), the two
// dividers run in parallel with an input register and one stage per quotient
// bit (FRAC_BITS+22 stages), then an output register.
// Throughput is one item per cycle while the output is not stalled. The whole
// pipe advances only when the output register is empty or being taken; a
// stall holds every stage, nothing lost or repeated.
// Reset clears all valid bits; the pipe is empty after reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit #(
  parameter int unsigned FRAC_BITS = qrs_pkg::FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // coef_square[15:0], coef_linear[31:16], coef_const[47:32]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // root_count[1:0], first_root[35:2], second_root[69:36], zero fill
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned SQ_STEPS = qrs_pkg::D_PAIRS + FRAC_BITS;
  localparam int unsigned NUM_W    = 19 + FRAC_BITS + 2;
  localparam int unsigned ROOT_W   = qrs_pkg::ROOT_W;

  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: products
  logic               v1_q;
  logic signed [15:0] a1_q, b1_q, c1_q;
  logic signed [31:0] bb1_q, ac1_q;
  // stage 2: discriminant
  logic               v2_q;
  logic signed [15:0] a2_q, b2_q, c2_q;
  logic signed [34:0] d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= s_axis_tdata[15:0];
      b1_q  <= s_axis_tdata[31:16];
      c1_q  <= s_axis_tdata[47:32];
      bb1_q <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]);
      ac1_q <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[47:32]);
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      c2_q  <= c1_q;
      d2_q  <= 35'(bb1_q) - (35'(ac1_q) <<< 2);
    end
  end

  // square root pipeline
  logic                 sv_q  [SQ_STEPS+1];
  logic [33:0]          sd_q  [SQ_STEPS+1];
  logic [SQ_STEPS+1:0]  srem_q[SQ_STEPS+1];
  logic [SQ_STEPS-1:0]  sroot_q[SQ_STEPS+1];
  logic signed [15:0]   sa_q  [SQ_STEPS+1];
  logic signed [15:0]   sb_q  [SQ_STEPS+1];
  logic signed [15:0]   sc_q  [SQ_STEPS+1];
  logic                 sneg_q[SQ_STEPS+1];
  logic                 szero_q[SQ_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= SQ_STEPS; i++) sv_q[i] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= v2_q;
      for (int i = 1; i <= SQ_STEPS; i++) sv_q[i] <= sv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0]    <= d2_q[33:0];
      sneg_q[0]  <= d2_q[34];
      szero_q[0] <= (d2_q == '0);
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
      sa_q[0]    <= a2_q;
      sb_q[0]    <= b2_q;
      sc_q[0]    <= c2_q;
      for (int i = 1; i <= SQ_STEPS; i++) begin
        logic [SQ_STEPS+1:0] r, t;
        logic [1:0]          pr;
        pr = sd_q[i-1][2*qrs_pkg::D_PAIRS-1 -: 2];
        r  = {srem_q[i-1][SQ_STEPS-1:0], pr};
        t  = {sroot_q[i-1], 2'b01};
        if (r >= t) begin
          srem_q[i]  <= r - t;
          sroot_q[i] <= {sroot_q[i-1][SQ_STEPS-2:0], 1'b1};
        end else begin
          srem_q[i]  <= r;
          sroot_q[i] <= {sroot_q[i-1][SQ_STEPS-2:0], 1'b0};
        end
        sd_q[i]    <= sd_q[i-1] << 2;
        sneg_q[i]  <= sneg_q[i-1];
        szero_q[i] <= szero_q[i-1];
        sa_q[i]    <= sa_q[i-1];
        sb_q[i]    <= sb_q[i-1];
        sc_q[i]    <= sc_q[i-1];
      end
    end
  end

  // divider inputs
  logic signed [15:0]    ea, eb, ec;
  logic signed [NUM_W-1:0] nb, s_ext, num1, num2;
  logic signed [17:0]    den;
  logic [1:0]            cnt;
  assign ea    = sa_q[SQ_STEPS];
  assign eb    = sb_q[SQ_STEPS];
  assign ec    = sc_q[SQ_STEPS];
  assign nb    = -(NUM_W'(eb) <<< FRAC_BITS);
  assign s_ext = $signed(NUM_W'(sroot_q[SQ_STEPS]));

  always_comb begin
    num1 = '0;
    num2 = '0;
    den  = 18'sd1;
    cnt  = 2'd0;
    if (ea == 0 && eb == 0) begin
      cnt = 2'd0;
    end else if (ea == 0) begin
      cnt  = 2'd1;
      num1 = -(NUM_W'(ec) <<< FRAC_BITS);
      den  = 18'(eb);
    end else if (!sneg_q[SQ_STEPS]) begin
      num1 = nb + s_ext;
      num2 = nb - s_ext;
      den  = 18'(ea) <<< 1;
      cnt  = szero_q[SQ_STEPS] ? 2'd1 : 2'd2;
    end
  end

  logic                    dv1, dv2;
  logic signed [NUM_W-1:0] q1, q2;
  logic [1:0]              t1, t2;

  qrs_divider #(.NUM_W(NUM_W), .DEN_W(18), .TAG_W(2)) u_div1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv_q[SQ_STEPS]),
    .num_i(num1), .den_i(den), .tag_i(cnt),
    .valid_o(dv1), .quo_o(q1), .tag_o(t1)
  );

  qrs_divider #(.NUM_W(NUM_W), .DEN_W(18), .TAG_W(2)) u_div2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv_q[SQ_STEPS]),
    .num_i(num2), .den_i(den), .tag_i(cnt),
    .valid_o(dv2), .quo_o(q2), .tag_o(t2)
  );

  function automatic logic [ROOT_W-1:0] sat(input logic signed [NUM_W-1:0] v);
    logic signed [63:0] w, hi, lo;
    w  = 64'(v);
    hi = (64'sd1 <<< (ROOT_W-1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (w > hi) return hi[ROOT_W-1:0];
    if (w < lo) return lo[ROOT_W-1:0];
    return w[ROOT_W-1:0];
  endfunction

  logic [1:0]        cnt_q;
  logic [ROOT_W-1:0] r1_q, r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_q <= t1;
      r1_q  <= (t1 == 2'd0) ? '0 : sat(q1);
      r2_q  <= (t2 == 2'd2) ? sat(q2) : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, r2_q, r1_q, cnt_q};

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 2'd3) else $error("bad root count");
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv1 == dv2) else $error("divider lanes out of step");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

// ===== dv/tb_quadratic_root_solver_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_unit
// Streams coefficient sets into the root solver, predicts each root count
// and fixed-point root pair, and checks results in order under random stalls.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_unit;

  typedef struct packed {
    logic [qrs_pkg::ROOT_W-1:0] second_root;
    logic [qrs_pkg::ROOT_W-1:0] first_root;
    logic [qrs_pkg::CNT_W-1:0]  root_count;
  } roots_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  logic [47:0] coef_sets[$];
  roots_t      roots_due[$];
  int          n_errors = 0;
  int          n_checked = 0;
  int          n_two = 0, n_one = 0, n_none = 0;
  bit          burst = 1'b0;
  bit          hold_tx = 1'b0;

  quadratic_root_solver_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned fixed_sqrt(longint unsigned d);
    longint unsigned rem, root, pair, trial;
    rem = 0;
    root = 0;
    for (int i = qrs_pkg::D_PAIRS - 1; i >= -int'(qrs_pkg::FRAC_BITS); i--) begin
      pair = (i >= 0) ? ((d >> (2 * i)) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root <<= 1;
      end
    end
    return root;
  endfunction

  function automatic logic [qrs_pkg::ROOT_W-1:0] clamp_root(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (qrs_pkg::ROOT_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[qrs_pkg::ROOT_W-1:0];
  endfunction

  function automatic roots_t solve_roots(logic [47:0] coefs);
    longint a, b, c, d, s, nb, den, r1, r2;
    roots_t r;
    a = longint'($signed(coefs[15:0]));
    b = longint'($signed(coefs[31:16]));
    c = longint'($signed(coefs[47:32]));
    r1 = 0;
    r2 = 0;
    r.root_count = 2'd0;
    if (a == 0 && b == 0) begin
      r.root_count = 2'd0;
    end else if (a == 0) begin
      r.root_count = 2'd1;
      r1 = (-c * (64'sd1 <<< qrs_pkg::FRAC_BITS)) / b;
    end else begin
      d = b * b - 4 * a * c;
      if (d >= 0) begin
        s = longint'(fixed_sqrt(d));
        nb = -b * (64'sd1 <<< qrs_pkg::FRAC_BITS);
        den = 2 * a;
        r1 = (nb + s) / den;
        if (d == 0) begin
          r.root_count = 2'd1;
        end else begin
          r.root_count = 2'd2;
          r2 = (nb - s) / den;
        end
      end
    end
    r.first_root = clamp_root(r1);
    r.second_root = clamp_root(r2);
    return r;
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'(int'($urandom_range(0, 6)) - 3);
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pack_coefs(int a, int b, int c);
    return {16'(c), 16'(b), 16'(a)};
  endfunction

  always @(posedge clk_i) begin
    if ($urandom_range(0, 999) < 3) burst <= ~burst;
  end

  always @(posedge clk_i) begin
    logic take;
    if (rst_ni) begin
      take = s_axis_tvalid && s_axis_tready;
      if (take) begin
        roots_due.insert(roots_due.size(), solve_roots(s_axis_tdata));
        void'(coef_sets.pop_front());
      end
      if ((!s_axis_tvalid || take) && coef_sets.size() > 0 && !hold_tx &&
          (burst || $urandom_range(0, 99) >= 35)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= coef_sets[0];
      end else if (take) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    roots_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[69:0];
        if (roots_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = roots_due.pop_front();
          n_checked++;
          case (want.root_count)
            2'd0: n_none++;
            2'd1: n_one++;
            default: n_two++;
          endcase
          if (got !== want || m_axis_tdata[71:70] !== 2'b00) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: exp cnt=%0d r1=%h r2=%h got cnt=%0d r1=%h r2=%h",
                       want.root_count, want.first_root, want.second_root,
                       got.root_count, got.first_root, got.second_root);
          end
        end
      end
      m_axis_tready <= burst || $urandom_range(0, 99) >= 35;
    end
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    coef_sets.insert(coef_sets.size(), pack_coefs(0, 0, 0));
    coef_sets.insert(coef_sets.size(), pack_coefs(0, 0, 5));
    coef_sets.insert(coef_sets.size(), pack_coefs(0, 3, -7));
    coef_sets.insert(coef_sets.size(), pack_coefs(0, -32768, 32767));
    coef_sets.insert(coef_sets.size(), pack_coefs(0, 1, -32768));
    coef_sets.insert(coef_sets.size(), pack_coefs(1, -2, 1));
    coef_sets.insert(coef_sets.size(), pack_coefs(1, 0, 1));
    coef_sets.insert(coef_sets.size(), pack_coefs(1, -3, 2));
    coef_sets.insert(coef_sets.size(), pack_coefs(32767, 1, 0));
    coef_sets.insert(coef_sets.size(), pack_coefs(-32768, -32768, 32767));
    coef_sets.insert(coef_sets.size(), pack_coefs(-32768, -32768, -32768));
    coef_sets.insert(coef_sets.size(), pack_coefs(32767, 32767, 32767));
    coef_sets.insert(coef_sets.size(), pack_coefs(32767, -32768, -32768));
    coef_sets.insert(coef_sets.size(), pack_coefs(1, -32768, -32768));
    coef_sets.insert(coef_sets.size(), pack_coefs(1, 32767, 32767));
    coef_sets.insert(coef_sets.size(), pack_coefs(-1, 0, 32767));
    coef_sets.insert(coef_sets.size(), pack_coefs(3, 65535 & 16'hFFFF, 0));
    coef_sets.insert(coef_sets.size(), pack_coefs(32767, 1, -1));
    coef_sets.insert(coef_sets.size(), pack_coefs(-1, 1, 0));
    coef_sets.insert(coef_sets.size(), pack_coefs(2, 4, 2));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (coef_sets.size() == 0 && !s_axis_tvalid);
    hold_tx = 1'b1;
    wait (roots_due.size() == 0);
    @(posedge clk_i);
    hold_tx = 1'b0;
    for (int i = 0; i < 1150; i++)
      coef_sets.insert(coef_sets.size(), {rand_coef(), rand_coef(), rand_coef()});
    wait (coef_sets.size() == 0 && !s_axis_tvalid && roots_due.size() == 0);
    repeat (2 * qrs_pkg::FRAC_BITS + 80) @(posedge clk_i);
    $display("checked %0d results: %0d with two roots, %0d with one, %0d with none",
             n_checked, n_two, n_one, n_none);
    $display("random stalls on both sides, %0d errors", n_errors);
    if (n_errors == 0 && roots_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
